/* src/fpc_pkg.sv */
package fpc_pkg;

  // Width of one stored color byte.
  localparam int unsigned ColorBits = 8;

  // Request kinds carried on the input tuser bit.
  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  // Status of a lookup transaction as it travels down the chain of cells.
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [ColorBits-1:0] color;
  } qry_stat_t;

endpackage

/* src/fpc_cell.sv */
module fpc_cell
  import fpc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Entry shift from the newer neighbor.
  input  logic                  shift_i,
  input  logic                  ent_valid_i,
  input  logic [COORD_BITS-1:0] ent_x_i,
  input  logic [COORD_BITS-1:0] ent_y_i,
  input  logic [ColorBits-1:0]  ent_color_i,
  output logic                  ent_valid_o,
  output logic [COORD_BITS-1:0] ent_x_o,
  output logic [COORD_BITS-1:0] ent_y_o,
  output logic [ColorBits-1:0]  ent_color_o,
  // Lookup transaction from the newer neighbor.
  input  qry_stat_t             qry_i,
  input  logic [COORD_BITS-1:0] qry_x_i,
  input  logic [COORD_BITS-1:0] qry_y_i,
  output qry_stat_t             qry_o,
  output logic [COORD_BITS-1:0] qry_x_o,
  output logic [COORD_BITS-1:0] qry_y_o
);

  logic                  ent_valid_q;
  logic [COORD_BITS-1:0] ent_x_q;
  logic [COORD_BITS-1:0] ent_y_q;
  logic [ColorBits-1:0]  ent_color_q;
  qry_stat_t             qry_d, qry_q;
  logic [COORD_BITS-1:0] qry_x_q;
  logic [COORD_BITS-1:0] qry_y_q;
  logic                  match;

  // Entry valid bit moves with the entry on every write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (shift_i) begin
      ent_valid_q <= ent_valid_i;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_x_q     <= ent_x_i;
      ent_y_q     <= ent_y_i;
      ent_color_q <= ent_color_i;
    end
  end

  // Newer cells sit first, so the first match along the chain is the newest one.
  assign match = ent_valid_q && (ent_x_q == qry_x_i) && (ent_y_q == qry_y_i);

  always_comb begin
    qry_d = qry_i;
    if (qry_i.valid && !qry_i.hit && match) begin
      qry_d.hit   = 1'b1;
      qry_d.color = ent_color_q;
    end
  end

  // Lookup status stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qry_q <= '0;
    end else begin
      qry_q <= qry_d;
    end
  end

  // Lookup coordinates travel alongside the status.
  always_ff @(posedge clk_i) begin
    qry_x_q <= qry_x_i;
    qry_y_q <= qry_y_i;
  end

  assign ent_valid_o = ent_valid_q;
  assign ent_x_o     = ent_x_q;
  assign ent_y_o     = ent_y_q;
  assign ent_color_o = ent_color_q;
  assign qry_o       = qry_q;
  assign qry_x_o     = qry_x_q;
  assign qry_y_o     = qry_y_q;

endmodule

/* src/fifo_replacement_pixel_cache.sv */
// Fully associative pixel store with first-in first-out replacement.
// Input channel (s_axis): tuser selects the transaction kind, 0 writes a pixel
// and 1 looks one up; tdata carries the column, the row and the color.
// Output channel (m_axis): one transaction per input transaction; tuser is the
// hit flag and tdata the color of the newest matching entry, 0 on a miss or write.
// Entries live in a row of CACHE_DEPTH cells, newest first. A write shifts the
// row by one cell, so the oldest entry drops off the far end when all are in use.
// A lookup walks down the row one cell per cycle, through the status register of
// each cell; a write result goes straight into the output register.
// One transaction is handled at a time: after a lookup has walked the cell row,
// its result loads the output register, where it sits until taken; no new
// transaction can enter while the walk is in progress.
// The result waits in an output register; the next transaction is accepted
// in the same cycle the waiting result is taken. If the receiver stalls, the
// result holds and no new transaction is accepted.
// Reset empties the store and the output register; no clearing pass is needed.
module fifo_replacement_pixel_cache
  import fpc_pkg::*;
#(
  parameter int unsigned CACHE_DEPTH = 16,
  parameter int unsigned COORD_BITS  = 12,
  localparam int unsigned InBits     = 2 * COORD_BITS + ColorBits,
  localparam int unsigned InBytes    = (InBits + 7) / 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0 up: x_coord, y_coord, pixel_color, zero fill.
  input  logic [8*InBytes-1:0] s_axis_tdata,
  // Fields from bit 0 up: func.
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0 up: found_color.
  output logic [ColorBits-1:0] m_axis_tdata,
  // Fields from bit 0 up: hit.
  output logic                 m_axis_tuser
);

  logic                  in_accept;
  logic                  is_write;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic [ColorBits-1:0]  in_color;
  qry_stat_t             qry_in;

  logic                  busy_d, busy_q;
  logic                  out_valid_d, out_valid_q;
  logic                  out_hit_d, out_hit_q;
  logic [ColorBits-1:0]  out_color_d, out_color_q;

  logic                  ent_valid [CACHE_DEPTH];
  logic [COORD_BITS-1:0] ent_x     [CACHE_DEPTH];
  logic [COORD_BITS-1:0] ent_y     [CACHE_DEPTH];
  logic [ColorBits-1:0]  ent_color [CACHE_DEPTH];
  qry_stat_t             qry       [CACHE_DEPTH];
  logic [COORD_BITS-1:0] qry_x     [CACHE_DEPTH];
  logic [COORD_BITS-1:0] qry_y     [CACHE_DEPTH];

  // Input field unpacking.
  assign in_x     = s_axis_tdata[COORD_BITS-1:0];
  assign in_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_color = s_axis_tdata[2*COORD_BITS+ColorBits-1:2*COORD_BITS];

  // Accept when idle and the output register is free or being emptied.
  assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign is_write      = (func_e'(s_axis_tuser) == FUNC_WRITE);

  // A lookup enters the first cell with no hit yet.
  always_comb begin
    qry_in       = '0;
    qry_in.valid = in_accept && !is_write;
  end

  // Row of cells, newest entry in cell 0.
  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      fpc_cell #(
        .COORD_BITS(COORD_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_accept && is_write),
        .ent_valid_i(1'b1),
        .ent_x_i    (in_x),
        .ent_y_i    (in_y),
        .ent_color_i(in_color),
        .ent_valid_o(ent_valid[i]),
        .ent_x_o    (ent_x[i]),
        .ent_y_o    (ent_y[i]),
        .ent_color_o(ent_color[i]),
        .qry_i      (qry_in),
        .qry_x_i    (in_x),
        .qry_y_i    (in_y),
        .qry_o      (qry[i]),
        .qry_x_o    (qry_x[i]),
        .qry_y_o    (qry_y[i])
      );
    end else begin : g_body
      fpc_cell #(
        .COORD_BITS(COORD_BITS)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .shift_i    (in_accept && is_write),
        .ent_valid_i(ent_valid[i-1]),
        .ent_x_i    (ent_x[i-1]),
        .ent_y_i    (ent_y[i-1]),
        .ent_color_i(ent_color[i-1]),
        .ent_valid_o(ent_valid[i]),
        .ent_x_o    (ent_x[i]),
        .ent_y_o    (ent_y[i]),
        .ent_color_o(ent_color[i]),
        .qry_i      (qry[i-1]),
        .qry_x_i    (qry_x[i-1]),
        .qry_y_i    (qry_y[i-1]),
        .qry_o      (qry[i]),
        .qry_x_o    (qry_x[i]),
        .qry_y_o    (qry_y[i])
      );
    end
  end

  // Busy while a lookup walks the row.
  always_comb begin
    busy_d = busy_q;
    if (qry[CACHE_DEPTH-1].valid) begin
      busy_d = 1'b0;
    end else if (in_accept && !is_write) begin
      busy_d = 1'b1;
    end
  end

  // Output register loads on a write or at the end of a lookup walk.
  always_comb begin
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_color_d = out_color_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_accept && is_write) begin
      out_valid_d = 1'b1;
      out_hit_d   = 1'b0;
      out_color_d = '0;
    end else if (qry[CACHE_DEPTH-1].valid) begin
      out_valid_d = 1'b1;
      out_hit_d   = qry[CACHE_DEPTH-1].hit;
      out_color_d = qry[CACHE_DEPTH-1].color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q   <= out_hit_d;
    out_color_q <= out_color_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_color_q;

endmodule
